FILE: sv/rtcm3v_pkg.sv
package rtcm3v_pkg;

  localparam int unsigned DataW   = 8;
  localparam int unsigned CrcW    = 24;
  localparam int unsigned CountW  = 11;
  localparam int unsigned LenW    = 10;
  localparam int unsigned StatusW = 3;

  localparam logic [DataW-1:0]  PREAMBLE_CODE    = 8'hD3;
  // crc-24q generator without its implicit top bit
  localparam logic [CrcW-1:0]   CRC_POLY         = 24'h864CFB;
  localparam logic [CountW-1:0] COUNT_MAX        = 11'd2047;
  // header (3 bytes) plus crc (3 bytes)
  localparam logic [CountW-1:0] HDR_CRC_BYTES    = 11'd6;
  localparam logic [CountW-1:0] MIN_FRAME_BYTES  = 11'd3;

  typedef enum logic [StatusW-1:0] {
    STAT_OK       = 3'd0,
    STAT_PREAMBLE = 3'd1,
    STAT_RESERVED = 3'd2,
    STAT_LENGTH   = 3'd3,
    STAT_CRC      = 3'd4
  } status_e;

endpackage

FILE: sv/rtcm3v_if.sv
interface rtcm3v_byte_if;
  import rtcm3v_pkg::*;

  logic             valid;
  logic             ready;
  logic [DataW-1:0] data_byte;
  logic             last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface rtcm3v_status_if;
  import rtcm3v_pkg::*;

  logic               valid;
  logic               ready;
  logic [StatusW-1:0] frame_status;
  logic [LenW-1:0]    payload_length;

  modport source (output valid, output frame_status, output payload_length, input ready);
  modport sink   (input valid, input frame_status, input payload_length, output ready);
endinterface

FILE: sv/rtcm3v_crc24q.sv
module rtcm3v_crc24q import rtcm3v_pkg::*; (
  input  logic [CrcW-1:0]  crc_i,
  input  logic [DataW-1:0] data_i,
  output logic [CrcW-1:0]  crc_o
);

  // byte-parallel crc-24q, msb first
  always_comb begin
    logic [CrcW-1:0] c;
    c = crc_i ^ {data_i, {(CrcW-DataW){1'b0}}};
    for (int k = 0; k < DataW; k++) begin
      if (c[CrcW-1]) begin
        c = {c[CrcW-2:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[CrcW-2:0], 1'b0};
      end
    end
    crc_o = c;
  end

endmodule

FILE: sv/rtcm3_frame_validator_unit.sv
// rtcm3 frame validator
//
// frame_i carries one byte of a candidate rtcm3 frame per beat, first byte
// first, with last_byte set on the final byte of the container. status_o
// carries one beat per container: frame_status (0 ok, 1 bad preamble,
// 2 reserved bits set, 3 length mismatch, 4 crc mismatch) and the 10-bit
// payload_length taken from the header (0 for containers under 3 bytes).
//
// throughput: one byte per cycle while frame_i.ready is high. the crc-24q
// register takes a whole byte per cycle through a byte-parallel xor network,
// so every byte is folded into the running state in the cycle it is accepted.
// the status beat is registered; it is valid in the cycle after the last byte is
// accepted unless the output register holds a status not taken that cycle.
//
// the result side has an output register plus one skid register, so input
// beats keep flowing while a status waits; frame_i.ready drops only once
// both hold a status the receiver has not taken yet.
//
// reset clears the byte count, crc, header flags and the valid bits of both
// result slots; the block is ready for the first byte of a container right after reset.
module rtcm3_frame_validator_unit import rtcm3v_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  rtcm3v_byte_if.sink       frame_i,
  rtcm3v_status_if.source   status_o
);

  // running frame state
  logic [CountW-1:0] count_q;
  logic [CrcW-1:0]   crc_q;
  logic [LenW-1:0]   len_q;
  logic              preamble_bad_q;
  logic              reserved_bad_q;

  logic [CountW-1:0] count_inc;
  logic [CrcW-1:0]   crc_d;
  logic [LenW-1:0]   len_d;
  logic              preamble_bad_d;
  logic              reserved_bad_d;

  // result for the container that ends with this byte
  status_e           status_d;
  logic [LenW-1:0]   plen_d;

  // output register and skid slot
  logic              main_valid_q, skid_valid_q;
  status_e           main_status_q, skid_status_q;
  logic [LenW-1:0]   main_plen_q, skid_plen_q;

  logic accept;
  logic push;
  logic pop;

  assign frame_i.ready = ~skid_valid_q;
  assign accept        = frame_i.valid & frame_i.ready;
  assign push          = accept & frame_i.last_byte;
  assign pop           = main_valid_q & status_o.ready;

  rtcm3v_crc24q u_crc (
    .crc_i  (crc_q),
    .data_i (frame_i.data_byte),
    .crc_o  (crc_d)
  );

  // header capture as the first three bytes pass
  always_comb begin
    preamble_bad_d = preamble_bad_q;
    reserved_bad_d = reserved_bad_q;
    len_d          = len_q;
    case (count_q)
      11'd0: begin
        preamble_bad_d = (frame_i.data_byte != PREAMBLE_CODE);
      end
      11'd1: begin
        reserved_bad_d = |frame_i.data_byte[DataW-1:2];
        len_d          = {frame_i.data_byte[1:0], {(LenW-2){1'b0}}};
      end
      11'd2: begin
        len_d = {len_q[LenW-1:LenW-2], frame_i.data_byte};
      end
      default: begin
      end
    endcase
  end

  // saturating byte count, including the current byte
  assign count_inc = (count_q == COUNT_MAX) ? count_q : count_q + 11'd1;

  // check order: short container, preamble, reserved, length, crc residue
  always_comb begin
    plen_d = len_d;
    if (count_inc < MIN_FRAME_BYTES) begin
      status_d = STAT_LENGTH;
      plen_d   = '0;
    end else if (preamble_bad_d) begin
      status_d = STAT_PREAMBLE;
    end else if (reserved_bad_d) begin
      status_d = STAT_RESERVED;
    end else if (count_inc != ({1'b0, len_d} + HDR_CRC_BYTES)) begin
      status_d = STAT_LENGTH;
    end else if (crc_d != '0) begin
      status_d = STAT_CRC;
    end else begin
      status_d = STAT_OK;
    end
  end

  // frame state: fold the byte in, clear after the last byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q        <= '0;
      crc_q          <= '0;
      len_q          <= '0;
      preamble_bad_q <= 1'b0;
      reserved_bad_q <= 1'b0;
    end else if (accept) begin
      if (frame_i.last_byte) begin
        count_q        <= '0;
        crc_q          <= '0;
        len_q          <= '0;
        preamble_bad_q <= 1'b0;
        reserved_bad_q <= 1'b0;
      end else begin
        count_q        <= count_inc;
        crc_q          <= crc_d;
        len_q          <= len_d;
        preamble_bad_q <= preamble_bad_d;
        reserved_bad_q <= reserved_bad_d;
      end
    end
  end

  // result slot valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (pop) begin
        // skid moves up, or a fresh status lands directly
        main_valid_q <= skid_valid_q | push;
        skid_valid_q <= 1'b0;
      end else if (push) begin
        main_valid_q <= 1'b1;
        skid_valid_q <= main_valid_q;
      end
    end
  end

  // result slot payload
  always_ff @(posedge clk_i) begin
    if (pop) begin
      if (skid_valid_q) begin
        main_status_q <= skid_status_q;
        main_plen_q   <= skid_plen_q;
      end else if (push) begin
        main_status_q <= status_d;
        main_plen_q   <= plen_d;
      end
    end else if (push) begin
      if (main_valid_q) begin
        skid_status_q <= status_d;
        skid_plen_q   <= plen_d;
      end else begin
        main_status_q <= status_d;
        main_plen_q   <= plen_d;
      end
    end
  end

  assign status_o.valid          = main_valid_q;
  assign status_o.frame_status   = main_status_q;
  assign status_o.payload_length = main_plen_q;

endmodule

FILE: sv/rtcm3v_checker.sv
module rtcm3v_checker import rtcm3v_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_i,
  input logic               in_last_i,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input logic [StatusW-1:0] out_status_i,
  input logic [LenW-1:0]    out_plen_i
);

  // a status only appears after a container's last byte
  a_status_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_valid_i && in_ready_i && in_last_i))
    else $error("status beat without a preceding last byte");

  // bytes are only held back while a status is pending
  a_stall_needs_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i)
    else $error("input stalled with no status pending");

  // status code stays within the defined set
  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_status_i <= STAT_CRC))
    else $error("undefined frame status");

  // a stalled status beat holds
  a_status_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      out_valid_i && $stable(out_status_i) && $stable(out_plen_i))
    else $error("status beat changed while stalled");

endmodule

bind rtcm3_frame_validator_unit rtcm3v_checker u_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (frame_i.valid),
  .in_ready_i   (frame_i.ready),
  .in_last_i    (frame_i.last_byte),
  .out_valid_i  (status_o.valid),
  .out_ready_i  (status_o.ready),
  .out_status_i (status_o.frame_status),
  .out_plen_i   (status_o.payload_length)
);

FILE: sim/rtcm3_frame_validator_unit_tb.sv
module rtcm3_frame_validator_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rtcm3v_pkg::*;

  localparam int CLK_PERIOD   = 8;
  localparam int RESET_CYCLES = 9;
  // byte budget for the whole run, directed and oversized containers included
  localparam int TARGET_BYTES = 2000;
  // watchdog limit, this leaves plenty of slack for the whole run
  localparam int CYCLE_LIMIT  = 600000;
  // status beat is registered after the last byte and may wait in the skid slot first
  localparam int SETTLE_CYCLES = 8;

  // one byte beat as queued for the driver; hold_off makes the driver wait
  // until every outstanding status has come back before sending it
  typedef struct packed {
    logic [DataW-1:0] data;
    logic             last;
    logic             hold_off;
  } byte_beat_t;

  typedef struct packed {
    status_e         status;
    logic [LenW-1:0] plen;
  } status_beat_t;

  // ways a generated frame gets damaged
  typedef enum int {
    FLAW_NONE,
    FLAW_PREAMBLE,
    FLAW_RESERVED,
    FLAW_SHORT,
    FLAW_EXTRA,
    FLAW_CRC,
    FLAW_LENGTH_LIE
  } flaw_e;

  logic clk_i = 1'b0;
  logic rst_ni;

  rtcm3v_byte_if   frame_if ();
  rtcm3v_status_if status_if ();

  rtcm3_frame_validator_unit uut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .frame_i  (frame_if),
    .status_o (status_if)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // pending byte beats and the statuses they are expected to produce
  byte_beat_t       byte_q[$];
  status_beat_t     status_exp_q[$];
  logic [DataW-1:0] build_q[$];

  // frame checker state, mirrors what the block keeps per container
  logic [CountW-1:0] fc_count;
  logic [CrcW-1:0]   fc_crc;
  logic [LenW-1:0]   fc_len;
  logic              fc_preamble_bad;
  logic              fc_reserved_bad;

  int tx_gap, tx_run, rx_wait, rx_run;
  int n_queued, n_containers, n_bytes_sent, n_checked, n_errors;
  int status_seen[5];
  int cycle_cnt;

  // one byte of crc-24q, msb first, no reflection, no final xor
  function automatic logic [CrcW-1:0] crc24q_byte(input logic [CrcW-1:0] crc,
                                                  input logic [DataW-1:0] b);
    logic [CrcW-1:0] r;
    r = crc ^ {b, 16'h0000};
    for (int k = 0; k < 8; k++) begin
      r = r[CrcW-1] ? ((r << 1) ^ CRC_POLY) : (r << 1);
    end
    return r;
  endfunction

  // idle length for one beat; now and then a stretch with no idling at all
  function automatic int draw_wait(inout int run_left);
    if (run_left > 0) begin
      run_left--;
      return 0;
    end
    if ($urandom_range(0, 99) < 2) begin
      run_left = $urandom_range(20, 150);
      return 0;
    end
    return $urandom_range(0, 13);
  endfunction

  // fold one accepted byte into the checker, queue a status on the last one
  task automatic check_byte(input logic [DataW-1:0] b, input logic last);
    status_beat_t res;
    if (fc_count == 0) begin
      fc_preamble_bad = (b != PREAMBLE_CODE);
    end else if (fc_count == 1) begin
      fc_reserved_bad = (b[7:2] != 6'd0);
      fc_len          = {b[1:0], 8'h00};
    end else if (fc_count == 2) begin
      fc_len[7:0] = b;
    end
    fc_crc = crc24q_byte(fc_crc, b);
    if (fc_count != COUNT_MAX) fc_count++;

    if (last) begin
      if (fc_count < MIN_FRAME_BYTES) begin
        // header never completed: length error, no length reported
        res.status = STAT_LENGTH;
        res.plen   = '0;
      end else begin
        res.plen = fc_len;
        if (fc_preamble_bad)                               res.status = STAT_PREAMBLE;
        else if (fc_reserved_bad)                          res.status = STAT_RESERVED;
        else if (fc_count != CountW'(fc_len) + HDR_CRC_BYTES) res.status = STAT_LENGTH;
        else if (fc_crc != '0)                             res.status = STAT_CRC;
        else                                               res.status = STAT_OK;
      end
      status_exp_q.push_back(res);
      fc_count        = '0;
      fc_crc          = '0;
      fc_len          = '0;
      fc_preamble_bad = 1'b0;
      fc_reserved_bad = 1'b0;
    end
  endtask

  // move the container in build_q to the driver queue, last flag on its end
  task automatic flush_build(input bit hold_off);
    byte_beat_t bb;
    for (int i = 0; i < build_q.size(); i++) begin
      bb.data     = build_q[i];
      bb.last     = (i == build_q.size() - 1);
      bb.hold_off = hold_off && (i == 0);
      byte_q.push_back(bb);
    end
    n_queued += build_q.size();
    n_containers++;
    build_q.delete();
  endtask

  // header with hdr_len, body_len random payload bytes, crc, then the flaw
  task automatic queue_frame(input logic [LenW-1:0] hdr_len, input int body_len,
                             input flaw_e flaw, input bit hold_off);
    logic [CrcW-1:0]  crc;
    logic [DataW-1:0] b;
    int               pos;
    build_q.push_back(PREAMBLE_CODE);
    build_q.push_back({6'd0, hdr_len[9:8]});
    build_q.push_back(hdr_len[7:0]);
    for (int i = 0; i < body_len; i++) build_q.push_back(DataW'($urandom));

    if (flaw == FLAW_PREAMBLE) begin
      b = DataW'($urandom);
      while (b == PREAMBLE_CODE) b = DataW'($urandom);
      build_q[0] = b;
    end else if (flaw == FLAW_RESERVED) begin
      build_q[1][7:2] = 6'($urandom_range(1, 63));
    end

    // crc goes over whatever header was built, so only the intended check trips
    crc = '0;
    foreach (build_q[i]) crc = crc24q_byte(crc, build_q[i]);
    build_q.push_back(crc[23:16]);
    build_q.push_back(crc[15:8]);
    build_q.push_back(crc[7:0]);

    case (flaw)
      FLAW_SHORT: begin
        repeat ($urandom_range(1, 3)) void'(build_q.pop_back());
      end
      FLAW_EXTRA: begin
        repeat ($urandom_range(1, 3)) build_q.push_back(DataW'($urandom));
      end
      FLAW_CRC: begin
        // single bit error anywhere past the header, payload or crc bytes
        pos          = $urandom_range(3, build_q.size() - 1);
        build_q[pos] = build_q[pos] ^ (8'h01 << $urandom_range(0, 7));
      end
      default: ;
    endcase
    flush_build(hold_off);
  endtask

  // driver: presents queued beats, idles between them, predicts on acceptance
  always @(posedge clk_i or negedge rst_ni) begin
    byte_beat_t nxt;
    if (!rst_ni) begin
      frame_if.valid     <= 1'b0;
      frame_if.data_byte <= '0;
      frame_if.last_byte <= 1'b0;
      tx_gap = 0;
    end else begin
      if (frame_if.valid && frame_if.ready) begin
        check_byte(frame_if.data_byte, frame_if.last_byte);
        n_bytes_sent++;
      end
      if (frame_if.valid && !frame_if.ready) begin
        // beat still pending, keep it on the bus
        tx_gap = tx_gap;
      end else if (tx_gap > 0) begin
        tx_gap--;
        frame_if.valid <= 1'b0;
      end else if (byte_q.size() > 0 &&
                   !(byte_q[0].hold_off && status_exp_q.size() > 0)) begin
        nxt = byte_q.pop_front();
        frame_if.valid     <= 1'b1;
        frame_if.data_byte <= nxt.data;
        frame_if.last_byte <= nxt.last;
        tx_gap = draw_wait(tx_run);
      end else begin
        frame_if.valid <= 1'b0;
      end
    end
  end

  // monitor: takes status beats with random back-pressure, checks each one
  always @(posedge clk_i or negedge rst_ni) begin
    status_beat_t want;
    if (!rst_ni) begin
      status_if.ready <= 1'b0;
      rx_wait = 0;
    end else begin
      if (status_if.valid && status_if.ready) begin
        if (status_exp_q.size() == 0) begin
          n_errors++;
          $display("%0t: unexpected status beat, expected none, got status %0d length %0d",
                   $time, status_if.frame_status, status_if.payload_length);
        end else begin
          want = status_exp_q.pop_front();
          n_checked++;
          status_seen[int'(want.status)]++;
          if (status_if.frame_status !== want.status) begin
            n_errors++;
            $display("%0t: frame_status expected %0d got %0d",
                     $time, want.status, status_if.frame_status);
          end
          if (status_if.payload_length !== want.plen) begin
            n_errors++;
            $display("%0t: payload_length expected %0d got %0d",
                     $time, want.plen, status_if.payload_length);
          end
        end
        rx_wait = draw_wait(rx_run);
      end
      if (rx_wait > 0) begin
        rx_wait--;
        status_if.ready <= 1'b0;
      end else begin
        status_if.ready <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    int    pick, frame_no, body;
    bit    hold_off;
    flaw_e flaw;

    frame_if.valid     = 1'b0;
    frame_if.data_byte = '0;
    frame_if.last_byte = 1'b0;
    status_if.ready    = 1'b0;
    rst_ni             = 1'b0;
    fc_count           = '0;
    fc_crc             = '0;
    fc_len             = '0;
    fc_preamble_bad    = 1'b0;
    fc_reserved_bad    = 1'b0;
    tx_run             = 0;
    rx_run             = 0;
    n_queued           = 0;
    n_containers       = 0;
    n_bytes_sent       = 0;
    n_checked          = 0;
    n_errors           = 0;
    cycle_cnt          = 0;
    foreach (status_seen[i]) status_seen[i] = 0;

    // directed: one-byte and two-byte containers, header with no room for crc
    build_q.push_back(8'hFF);
    flush_build(1'b0);
    build_q.push_back(PREAMBLE_CODE);
    build_q.push_back(8'h03);
    flush_build(1'b0);
    build_q.push_back(PREAMBLE_CODE);
    build_q.push_back(8'h00);
    build_q.push_back(8'h00);
    flush_build(1'b0);
    // directed: empty payload frames, clean and with a crc, preamble or reserved-bits fault
    queue_frame(10'd0, 0, FLAW_NONE, 1'b0);
    queue_frame(10'd0, 0, FLAW_CRC, 1'b0);
    queue_frame(10'd0, 0, FLAW_PREAMBLE, 1'b0);
    queue_frame(10'd0, 0, FLAW_RESERVED, 1'b0);

    // random part; first frame waits until the directed statuses are all back
    frame_no = 0;
    while (n_queued < TARGET_BYTES) begin
      hold_off = (frame_no == 0) || ($urandom_range(0, 39) == 0);
      if (frame_no == 10) begin
        // oversized: longest legal frame, length field all ones
        queue_frame(10'd1023, 1023, FLAW_NONE, hold_off);
      end else begin
        pick = $urandom_range(0, 99);
        body = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 120) : $urandom_range(0, 24);
        if (pick < 55) begin
          queue_frame(LenW'(body), body, FLAW_NONE, hold_off);
        end else if (pick < 80) begin
          flaw = flaw_e'($urandom_range(int'(FLAW_PREAMBLE), int'(FLAW_LENGTH_LIE)));
          if (flaw == FLAW_LENGTH_LIE) begin
            // header claims any length, payload stays short
            queue_frame(LenW'($urandom_range(0, 1023)), $urandom_range(0, 20), flaw, hold_off);
          end else begin
            queue_frame(LenW'(body), body, flaw, hold_off);
          end
        end else begin
          // noise container, sometimes behind a good preamble
          repeat ($urandom_range(1, 12)) build_q.push_back(DataW'($urandom));
          if ($urandom_range(0, 1) == 1) build_q[0] = PREAMBLE_CODE;
          flush_build(hold_off);
        end
      end
      frame_no++;
    end

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    // all bytes accepted, then all statuses back, then a short quiet period
    while (byte_q.size() != 0 || frame_if.valid) @(posedge clk_i);
    while (status_exp_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("run covered %0d bytes in %0d containers, %0d status beats checked",
             n_bytes_sent, n_containers, n_checked);
    $display("status mix: ok %0d, preamble %0d, reserved %0d, length %0d, crc %0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3], status_seen[4]);
    if (n_errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
